>>> sv/bate_pkg.sv
// Shared constants, codes and types for the bounded array table engine.
package bate_pkg;

  // Capacity of the list and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int POS_W    = 7;
  localparam int CNTO_W   = 7;
  localparam int STAT_W   = 2;
  localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SUM    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e_t;

  // Control broadcast to every cell of the ring
  typedef struct packed {
    logic              rotate;
    logic              shift;
    logic              load;
    logic [IDX_W-1:0]  shift_from;
    logic [IDX_W-1:0]  load_at;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> sv/bate_cell.sv
// One storage cell of the entry ring: holds one entry, takes its neighbor's word.
module bate_cell (
  input  logic                      clk,
  input  logic [bate_pkg::IDX_W-1:0] idx,
  input  bate_pkg::cell_ctrl_t      ctrl,
  input  logic [bate_pkg::DATA_W-1:0] nbr_in,
  output logic [bate_pkg::DATA_W-1:0] entry
);
  import bate_pkg::*;

  // Rotate the ring, close a gap above the removed slot, or take an appended value
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      entry <= nbr_in;
    end else if (ctrl.shift && (idx >= ctrl.shift_from)) begin
      entry <= nbr_in;
    end else if (ctrl.load && (idx == ctrl.load_at)) begin
      entry <= ctrl.value;
    end
  end

endmodule

>>> sv/bounded_array_table_engine_top.sv
// Top level of the bounded array table engine: controller, cell ring and result register.
// Holds up to CAPACITY (64) signed 32-bit entries in a ring of cells and serves one
// request at a time; in_stall is high from acceptance until the result is registered.
// Insert and a remove at a bad position go straight to the finish state after
// acceptance; sum of evens, search and a good remove scan first, because the whole
// ring rotates once past its head cell, one entry per cycle, to restore order, and a
// good remove then spends a shift step closing the gap. The next request can be
// taken in the same cycle as the result beat appears.
// The result register lets the next request enter while a result beat still waits.
module bounded_array_table_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bate_pkg::REQ_W-1:0]    req_type,
  input  logic signed [bate_pkg::DATA_W-1:0] item_value,
  input  logic [bate_pkg::POS_W-1:0]    slot_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bate_pkg::STAT_W-1:0]   status_code,
  output logic                          found_flag,
  output logic signed [bate_pkg::DATA_W-1:0] even_sum,
  output logic signed [bate_pkg::DATA_W-1:0] removed_value,
  output logic [bate_pkg::CNTO_W-1:0]   entry_count
);
  import bate_pkg::*;

  state_e_t          state;
  state_e_t          state_next;
  logic [CNT_W-1:0]  count;
  req_e_t            req;
  logic [DATA_W-1:0] val;
  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  step;
  logic [DATA_W-1:0] acc;
  logic              found;
  logic [DATA_W-1:0] removed;
  status_e_t         status;

  logic              accept;
  logic              out_load;
  logic              is_full;
  logic              pos_bad;
  logic              step_last;
  logic              in_range;
  logic [WIDE_W-1:0] pos_m1;
  logic [DATA_W-1:0] head;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] entry [CAPACITY];

  // Decode the request and the scan position
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign pos_bad   = (slot_position == '0) || (WIDE_W'(slot_position) > WIDE_W'(count));
  assign pos_m1    = WIDE_W'(pos) - WIDE_W'(1);
  assign step_last = (step == IDX_W'(CAPACITY - 1));
  assign in_range  = (WIDE_W'(step) < WIDE_W'(count));
  assign head      = entry[0];
  assign out_load  = (state == S_FINISH) && (!out_valid || !out_stall);

  // Next state and cell control
  always_comb begin
    state_next      = state;
    ctrl.rotate     = 1'b0;
    ctrl.shift      = 1'b0;
    ctrl.load       = 1'b0;
    ctrl.shift_from = IDX_W'(pos_m1);
    ctrl.load_at    = IDX_W'(count);
    ctrl.value      = item_value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_e_t'(req_type))
            REQ_INSERT: begin
              ctrl.load  = !is_full;
              state_next = S_FINISH;
            end
            REQ_REMOVE: state_next = pos_bad ? S_FINISH : S_SCAN;
            default:    state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.rotate = 1'b1;
        if (step_last) begin
          state_next = (req == REQ_REMOVE) ? S_SHIFT : S_FINISH;
        end
      end
      S_SHIFT: begin
        ctrl.shift = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.shift) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Latch the request and accumulate over the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= req_e_t'(req_type);
      val     <= item_value;
      pos     <= slot_position;
      step    <= '0;
      acc     <= '0;
      found   <= 1'b0;
      removed <= '0;
      status  <= ST_OK;
      if ((req_e_t'(req_type) == REQ_INSERT) && is_full) begin
        status <= ST_FULL;
      end else if ((req_e_t'(req_type) == REQ_REMOVE) && pos_bad) begin
        status <= ST_BADPOS;
      end
    end else if (state == S_SCAN) begin
      step <= step + IDX_W'(1);
      if (in_range) begin
        if ((req == REQ_SUM) && !head[0]) begin
          acc <= acc + head;
        end
        if ((req == REQ_SEARCH) && (head == val)) begin
          found <= 1'b1;
        end
        if ((req == REQ_REMOVE) && (WIDE_W'(step) == pos_m1)) begin
          removed <= head;
        end
      end
    end
  end

  // Ring of cells: each takes the word of the next, the last wraps to the head
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    bate_cell u_cell (
      .clk    (clk),
      .idx    (IDX_W'(k)),
      .ctrl   (ctrl),
      .nbr_in (entry[(k + 1) % CAPACITY]),
      .entry  (entry[k])
    );
  end

  // Result register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_code   <= status;
      found_flag    <= found;
      even_sum      <= acc;
      removed_value <= removed;
      entry_count   <= CNTO_W'(count);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_beat_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result beat raised outside finish");

  a_shift_lowers_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |=> (count == $past(count) - CNT_W'(1)))
    else $error("remove did not lower count by one");

  a_shift_good_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> ((pos != '0) && (WIDE_W'(pos) <= WIDE_W'(count))))
    else $error("gap closed for a bad position");
`endif

endmodule

>>> tb/bounded_array_table_engine_top_test.sv
// Testbench for the bounded array table engine: drives list requests and checks every result beat.
module bounded_array_table_engine_top_test;
  import bate_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_TAIL   = 200;
  localparam int MAX_PRINTS   = 40;
  localparam int DRAIN_CYCLES = 80;

  // Request mixes for the random part
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  // Expected answer to one request
  typedef struct {
    status_e_t         status;
    logic              found;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] removed;
    logic [CNTO_W-1:0] count;
  } answer_t;

  // List predictor plus the queue of answers still owed by the block
  class list_scoreboard;
    logic signed [DATA_W-1:0] held[$];
    answer_t                  answers[$];
    int                       mismatches;

    function void note_request(req_e_t kind, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] position);
      answer_t a;
      a.status  = ST_OK;
      a.found   = 1'b0;
      a.sum     = '0;
      a.removed = '0;
      case (kind)
        REQ_INSERT: begin
          if (held.size() < CAPACITY) begin
            held.push_back(value);
          end else begin
            a.status = ST_FULL;
          end
        end
        REQ_SUM: begin
          // even means lowest bit clear, negative entries included
          foreach (held[i])
            if (!held[i][0]) a.sum += held[i];
        end
        REQ_SEARCH: begin
          foreach (held[i])
            if (held[i] == value) a.found = 1'b1;
        end
        REQ_REMOVE: begin
          if (position == 0 || position > held.size()) begin
            a.status = ST_BADPOS;
          end else begin
            a.removed = held[position - 1];
            held.delete(position - 1);
          end
        end
      endcase
      a.count = CNTO_W'(held.size());
      answers.push_back(a);
    endfunction

    task check_result(logic [STAT_W-1:0] got_status, logic got_found,
                      logic [DATA_W-1:0] got_sum, logic [DATA_W-1:0] got_removed,
                      logic [CNTO_W-1:0] got_count);
      answer_t a;
      if (answers.size() == 0) begin
        report_mismatch("result beat with no request waiting", '0, '0);
        return;
      end
      a = answers.pop_front();
      if (got_status !== a.status)
        report_mismatch("status_code", DATA_W'(got_status), DATA_W'(a.status));
      if (got_found !== a.found)
        report_mismatch("found_flag", DATA_W'(got_found), DATA_W'(a.found));
      if (got_sum !== a.sum) report_mismatch("even_sum", got_sum, a.sum);
      if (got_removed !== a.removed) report_mismatch("removed_value", got_removed, a.removed);
      if (got_count !== a.count)
        report_mismatch("entry_count", DATA_W'(got_count), DATA_W'(a.count));
    endtask

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (mismatches < MAX_PRINTS)
        $display("mismatch at %0t on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask
  endclass

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         req_type      = REQ_INSERT;
  logic signed [DATA_W-1:0] item_value    = '0;
  logic [POS_W-1:0]         slot_position = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [STAT_W-1:0]        status_code;
  logic                     found_flag;
  logic signed [DATA_W-1:0] even_sum;
  logic signed [DATA_W-1:0] removed_value;
  logic [CNTO_W-1:0]        entry_count;

  bit             idle_on      = 1'b1;
  int             hold_request = 0;
  list_scoreboard sb           = new();

  bounded_array_table_engine_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .item_value    (item_value),
    .slot_position (slot_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status_code   (status_code),
    .found_flag    (found_flag),
    .even_sum      (even_sum),
    .removed_value (removed_value),
    .entry_count   (entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pick a value biased toward extremes, zero, small numbers and even words
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh80000000;
      1:       return 32'sh7FFFFFFF;
      2:       return ($urandom_range(0, 1) != 0) ? -1 : 0;
      3:       return $signed($urandom_range(0, 20)) - 10;
      4:       return $urandom & ~32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request beat and hold it until the block takes it
  task automatic send_request(input req_e_t kind, input logic signed [DATA_W-1:0] value,
                              input logic [POS_W-1:0] position);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    item_value    <= value;
    slot_position <= position;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, value, position);
  endtask

  // Drop valid and wait until every owed answer has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.answers.size() != 0);
  endtask

  // Build one random request under the given mix
  task automatic random_request(input int mode);
    int                       roll;
    int                       held_now;
    int                       t_ins;
    int                       t_sum;
    int                       t_srch;
    req_e_t                   kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    roll     = $urandom_range(0, 99);
    held_now = sb.held.size();
    value    = random_value();
    position = POS_W'($urandom_range(0, CAPACITY));
    case (mode)
      MIX_GROW: begin
        t_ins = 70; t_sum = 80; t_srch = 90;
      end
      MIX_SHRINK: begin
        t_ins = 15; t_sum = 25; t_srch = 40;
      end
      default: begin
        t_ins = 35; t_sum = 50; t_srch = 75;
      end
    endcase
    if (roll < t_ins) kind = REQ_INSERT;
    else if (roll < t_sum) kind = REQ_SUM;
    else if (roll < t_srch) kind = REQ_SEARCH;
    else kind = REQ_REMOVE;
    // aim searches at held entries half the time
    if (kind == REQ_SEARCH && held_now > 0 && $urandom_range(0, 1) != 0)
      value = sb.held[$urandom_range(0, held_now - 1)];
    // keep most removes at a valid position
    if (kind == REQ_REMOVE && held_now > 0 && $urandom_range(0, 4) != 0)
      position = POS_W'($urandom_range(1, held_now));
    send_request(kind, value, position);
  endtask

  // Accept result beats and throttle the output side
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_result(status_code, found_flag, even_sum, removed_value, entry_count);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Reset, directed requests, random requests, then the verdict
  initial begin : request_side
    int n;
    int mode;
    int seg_left;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list: sum and search give zero, any remove is a bad position
    send_request(REQ_SUM, 0, 0);
    send_request(REQ_SEARCH, 0, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 0, 1);
    // extremes, odd and even, negative even entries
    send_request(REQ_INSERT, 32'sh7FFFFFFF, 0);
    send_request(REQ_INSERT, 32'sh80000000, 0);
    send_request(REQ_INSERT, -2, 0);
    send_request(REQ_INSERT, 0, 0);
    send_request(REQ_INSERT, -1, 0);
    send_request(REQ_INSERT, 32'sh7FFFFFFE, 0);
    send_request(REQ_INSERT, 5, 0);
    // sum wraps past 2^32
    send_request(REQ_SUM, 0, 0);
    send_request(REQ_SEARCH, -1, 0);
    send_request(REQ_SEARCH, 32'sh80000000, 0);
    send_request(REQ_SEARCH, 6, 0);
    // bad positions: zero, one past the end, far past the end
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 0, 8);
    send_request(REQ_REMOVE, 0, 64);
    // good removes: head, tail, middle
    send_request(REQ_REMOVE, 0, 1);
    send_request(REQ_REMOVE, 0, 6);
    send_request(REQ_REMOVE, 0, 3);
    send_request(REQ_SEARCH, 32'sh7FFFFFFF, 0);
    send_request(REQ_SUM, 0, 0);

    // fill the list, then hit it while full
    while (sb.held.size() < CAPACITY) send_request(REQ_INSERT, random_value(), 0);
    send_request(REQ_INSERT, 32'sh12345678, 0);
    send_request(REQ_SEARCH, sb.held[CAPACITY-1], 0);
    send_request(REQ_SUM, 0, 0);
    send_request(REQ_REMOVE, 0, 64);
    send_request(REQ_REMOVE, 0, 64);

    // random segments that grow, shrink or churn the list
    mode     = MIX_GROW;
    seg_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(MIX_GROW, MIX_EVEN);
        seg_left = $urandom_range(40, 120);
      end
      seg_left--;
      if (n == 600) hold_request = 250;
      if (n == 1200) drain_results();
      if (n == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      random_request(mode);
    end
    in_valid <= 1'b0;

    while (sb.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
